// File: rtl/core/hpc_pkg.sv
// shared types, constants and crc step function for the header parse and crc check block
package hpc_pkg;

    localparam int unsigned HdrBytes = 22;
    localparam int unsigned CrcBytes = 18;
    localparam int unsigned PosW     = 5;
    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CfgDataW = 32;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // field positions inside the header
    localparam logic [PosW-1:0] POS_VERSION = PosW'(4);
    localparam logic [PosW-1:0] POS_TYPE    = PosW'(5);
    localparam logic [PosW-1:0] POS_LENGTH  = PosW'(14);
    localparam logic [PosW-1:0] POS_CRC     = PosW'(CrcBytes);
    localparam logic [PosW-1:0] POS_LAST    = PosW'(HdrBytes - 1);

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_MAGIC   = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_VERSION = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_MAGIC   = 2'd1,
        ST_BAD_VERSION = 2'd2,
        ST_BAD_CRC     = 2'd3
    } t_status;

    // control word for the crc register
    typedef struct packed {
        logic update;   // fold the word into the crc
        logic restart;  // start from all ones instead of the running value
    } t_crc_ctl;

    // reflected crc-32 over one word, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/hpc_crc.sv
// running crc-32 register with a one-word update per cycle
module hpc_crc
    import hpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctl    i_ctl,
    input  logic [7:0]  i_data,
    output logic [31:0] o_crc
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] base;

    // start value, then one word folded in
    always_comb begin
        base  = i_ctl.restart ? CRC_ONES : r_crc;
        n_crc = i_ctl.update ? crc_byte(base, i_data) : r_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_ONES;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

// File: rtl/core/header_parse_crc_check_unit.sv
// top level of the header parser and crc checker
//
// Input channel: one header word (byte) per accepted word, i_in_valid with
// o_in_stall; i_frame_start marks byte 0 and restarts capture at any time.
// Words that arrive while idle without the start flag are dropped.
// Output channel: o_out_valid with i_out_stall, one result per 22-byte
// header holding status, type, session, payload length and received crc.
// Config channel: i_cfg_valid with o_cfg_ready (always high), index 0
// writes the expected magic, index 1 the expected version.
// Throughput: one word per cycle unless stalled; the crc folds one byte
// per cycle. Latency: the result is shown the cycle after the last header
// word is accepted. The result register holds while the receiver stalls;
// the input is stalled only when the last word of the next header arrives
// while the previous result is still waiting.
// Reset (synchronous, active low): idle, no result pending, expected
// magic 0, expected version 1.
module header_parse_crc_check_unit
    import hpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input words
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_header_byte,
    input  logic                i_frame_start,
    // results
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [7:0]          o_message_type,
    output logic [63:0]         o_session,
    output logic [31:0]         o_payload_length,
    output logic [31:0]         o_received_crc,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    logic [31:0]     r_exp_magic;
    logic [7:0]      r_exp_version;
    logic [PosW-1:0] r_pos;
    logic [PosW-1:0] n_pos;
    logic [31:0]     r_magic;
    logic [7:0]      r_version;
    logic [7:0]      r_type;
    logic [63:0]     r_session;
    logic [31:0]     r_length;
    logic [23:0]     r_crc_hi;
    logic            r_out_valid;
    logic [1:0]      r_status;
    logic [7:0]      r_out_type;
    logic [63:0]     r_out_session;
    logic [31:0]     r_out_length;
    logic [31:0]     r_out_crc;

    logic            in_take;
    logic            active;
    logic [PosW-1:0] pos;
    logic            last;
    logic            out_take;
    logic [31:0]     run_crc;
    logic [31:0]     crc_seen;
    t_crc_ctl        crc_ctl;
    t_status         status;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall && (r_pos == POS_LAST);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;

    // byte position of the incoming word
    always_comb begin
        active = in_take && (i_frame_start || (r_pos != '0));
        pos    = i_frame_start ? '0 : r_pos;
        last   = active && (pos == POS_LAST);
        n_pos  = r_pos;
        if (active) begin
            n_pos = last ? '0 : pos + PosW'(1);
        end
    end

    // crc covers the first eighteen words
    assign crc_ctl.update  = active && (pos < POS_CRC);
    assign crc_ctl.restart = i_frame_start;

    hpc_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .i_data  (i_header_byte),
        .o_crc   (run_crc)
    );

    // checks in order, first failure wins
    assign crc_seen = {r_crc_hi, i_header_byte};
    always_comb begin
        if (r_magic != r_exp_magic) begin
            status = ST_BAD_MAGIC;
        end else if (r_version != r_exp_version) begin
            status = ST_BAD_VERSION;
        end else if (crc_seen != ~run_crc) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= '0;
            r_exp_version <= 8'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_exp_magic   <= i_cfg_data[31:0];
                CFG_VERSION: r_exp_version <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // field capture; all but the last crc byte are shifted in before use
    always_ff @(posedge i_clk) begin
        if (active) begin
            if (pos < POS_VERSION) begin
                r_magic <= {r_magic[23:0], i_header_byte};
            end else if (pos == POS_VERSION) begin
                r_version <= i_header_byte;
            end else if (pos == POS_TYPE) begin
                r_type <= i_header_byte;
            end else if (pos < POS_LENGTH) begin
                r_session <= {r_session[55:0], i_header_byte};
            end else if (pos < POS_CRC) begin
                r_length <= {r_length[23:0], i_header_byte};
            end else begin
                r_crc_hi <= {r_crc_hi[15:0], i_header_byte};
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (last) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last) begin
            r_status      <= status;
            r_out_type    <= r_type;
            r_out_session <= r_session;
            r_out_length  <= r_length;
            r_out_crc     <= crc_seen;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_message_type   = r_out_type;
    assign o_session        = r_out_session;
    assign o_payload_length = r_out_length;
    assign o_received_crc   = r_out_crc;

endmodule

// File: rtl/core/hpc_checker.sv
// port-level checks for the header parser, bound to the top level
module hpc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall
);

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // input is only held back by a waiting, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a pending result");

    // a new result follows an accepted word
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("result without an accepted word");

    // reset clears the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind header_parse_crc_check_unit hpc_checker u_hpc_checker (.*);
